FILE: hw/rtl/bpc_pkg.sv
// Package for the barometric pressure compensation unit.
// Holds calibration indexes, command codes and shared constants; no dependencies.
package bpc_pkg;
	localparam logic [1:0] CMD_CALIB = 2'd0;
	localparam logic [1:0] CMD_TEMP  = 2'd1;
	localparam logic [1:0] CMD_PRES  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;  // reserved, dropped without a result

	localparam int NUM_CALIB = 11;
	localparam logic [3:0] CAL_AC1 = 4'd0;
	localparam logic [3:0] CAL_AC2 = 4'd1;
	localparam logic [3:0] CAL_AC3 = 4'd2;
	localparam logic [3:0] CAL_AC4 = 4'd3;
	localparam logic [3:0] CAL_AC5 = 4'd4;
	localparam logic [3:0] CAL_AC6 = 4'd5;
	localparam logic [3:0] CAL_B1  = 4'd6;
	localparam logic [3:0] CAL_B2  = 4'd7;
	localparam logic [3:0] CAL_MB  = 4'd8;
	localparam logic [3:0] CAL_MC  = 4'd9;
	localparam logic [3:0] CAL_MD  = 4'd10;

	// shared divider request
	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
	} div_rsp_t;
endpackage

FILE: hw/rtl/bpc_in_if.sv
// Input channel interface of the compensation unit.
// Depends on nothing.
interface bpc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [3:0]  calib_index;
	logic [15:0] calib_word;
	logic [23:0] raw_sample;
	logic        transfer_ok;
	modport source(output valid, command, calib_index, calib_word, raw_sample, transfer_ok,
		input ready);
	modport sink(input valid, command, calib_index, calib_word, raw_sample, transfer_ok,
		output ready);
endinterface

FILE: hw/rtl/bpc_out_if.sv
// Result channel interface of the compensation unit.
// Depends on nothing.
interface bpc_out_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic signed [15:0] temperature_tenths;
	logic signed [18:0] pressure_pa;
	logic               divide_error;
	modport source(output valid, result_kind, temperature_tenths, pressure_pa, divide_error,
		input ready);
	modport sink(input valid, result_kind, temperature_tenths, pressure_pa, divide_error,
		output ready);
endinterface

FILE: hw/rtl/bpc_cfg_if.sv
// Configuration write channel carrying the oversampling setting.
// Depends on nothing.
interface bpc_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

FILE: hw/rtl/bpc_div.sv
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// Depends on bpc_pkg.
module bpc_div
	import bpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
endmodule

FILE: hw/rtl/barometric_pressure_compensation_unit.sv
// Top level of the barometric pressure compensation unit: sequencer, shared multiplier,
// calibration store. Depends on bpc_pkg, the channel interfaces and bpc_div.
//
//  channel | dir | carries
//  in_ch   | in  | command, calib_index, calib_word, raw_sample, transfer_ok
//  out_ch  | out | result_kind, temperature_tenths, pressure_pa, divide_error
//  cfg_ch  | in  | oversampling (2 bits)
//
// A calibration load, a failed transfer or an ignored command leaves the unit idle. A
// temperature item offers its result after a multiplier step and the bit-serial divider,
// a pressure item after steps on both sides of the divider, one shared 32x32 multiplier
// step per cycle. A zero divisor skips the divider; once the result is taken, it idles.
// Reset clears the sequencer, the temperature term and oversampling; the calibration
// store is not cleared. While a result waits on out_ch the unit takes no new item.
module barometric_pressure_compensation_unit
	import bpc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	bpc_in_if.sink    in_ch,
	bpc_out_if.source out_ch,
	bpc_cfg_if.sink   cfg_ch
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_T1   = 5'd1;  // x1 = (ut-ac6)*ac5 >> 15
	localparam logic [4:0] S_T2   = 5'd2;  // den, start divide
	localparam logic [4:0] S_TDIV = 5'd3;
	localparam logic [4:0] S_P1   = 5'd4;  // sq = b6*b6 >> 12
	localparam logic [4:0] S_P2   = 5'd5;  // b2*sq >> 11
	localparam logic [4:0] S_P3   = 5'd6;  // ac2*b6 >> 11
	localparam logic [4:0] S_P4   = 5'd7;  // b7
	localparam logic [4:0] S_P5   = 5'd8;  // ac3*b6 >> 13
	localparam logic [4:0] S_P6   = 5'd9;  // b1*sq >> 16
	localparam logic [4:0] S_P7   = 5'd10; // b4
	localparam logic [4:0] S_P8   = 5'd11; // start divide
	localparam logic [4:0] S_PDIV = 5'd12;
	localparam logic [4:0] S_P9   = 5'd13; // (p>>8)^2
	localparam logic [4:0] S_P10  = 5'd14; // *3038
	localparam logic [4:0] S_P11  = 5'd15; // -7357*p
	localparam logic [4:0] S_P12  = 5'd16; // final
	localparam logic [4:0] S_OUT  = 5'd17;

	logic [4:0]  state_q;
	logic [15:0] cal_q [NUM_CALIB];
	logic signed [31:0] term_q, a_q, b_q, c_q, d_q;
	logic [31:0] b7_q, b4_q;
	logic [23:0] raw_q;
	logic [1:0]  oss_q;
	logic        kind_q, err_q, neg_q, big_q;
	logic signed [15:0] tout_q;
	logic signed [18:0] pout_q;

	logic signed [31:0] mul_a, mul_b, mul_p;
	logic signed [63:0] mul_full;
	div_req_t dreq;
	div_rsp_t drsp;

	bpc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	function automatic logic signed [31:0] cs(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction
	function automatic logic signed [31:0] cu(input logic [15:0] v);
		return {16'd0, v};
	endfunction

	// shared multiplier, one operand pair per cycle
	assign mul_full = mul_a * mul_b;
	assign mul_p    = mul_full[31:0];

	logic signed [31:0] b6, sum, t4;
	logic [31:0] x3p, upv, b3;
	logic signed [31:0] pnew;

	always_comb begin
		b6 = term_q - 32'sd4000;
		x3p = 32'(((b_q + d_q + 32'sd2) >>> 2)) + 32'd32768;
		upv = {8'd0, raw_q} >> (4'd8 - {2'd0, oss_q});
		// b3 from b_q (x1+x2 = x3)
		b3  = 32'((((cs(cal_q[CAL_AC1]) <<< 2) + b_q) <<< oss_q) + 32'sd2) >>> 2;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_T1: begin mul_a = cu({8'd0, raw_q[15:8]} << 8 | {8'd0, raw_q[7:0]}) - cu(cal_q[CAL_AC6]);
				mul_b = cu(cal_q[CAL_AC5]); end
			S_P1: begin mul_a = b6; mul_b = b6; end
			S_P2: begin mul_a = cs(cal_q[CAL_B2]); mul_b = a_q; end
			S_P3: begin mul_a = cs(cal_q[CAL_AC2]); mul_b = b6; end
			// low product bits are the same for signed and unsigned operands
			S_P4: begin mul_a = $signed(upv - b3); mul_b = $signed(32'd50000 >> oss_q); end
			S_P5: begin mul_a = cs(cal_q[CAL_AC3]); mul_b = b6; end
			S_P6: begin mul_a = cs(cal_q[CAL_B1]); mul_b = a_q; end
			S_P7: begin mul_a = $signed(x3p); mul_b = cu(cal_q[CAL_AC4]); end
			S_P9: begin mul_a = c_q >>> 8; mul_b = c_q >>> 8; end
			S_P10: begin mul_a = a_q; mul_b = 32'sd3038; end
			S_P11: begin mul_a = -32'sd7357; mul_b = c_q; end
			default: ;
		endcase
		sum = term_q + 32'sd8;
		t4  = sum >>> 4;
		pnew = c_q + ((a_q + b_q + 32'sd3791) >>> 4);
	end

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		if (v > 32'sd32767) return 16'sh7fff;
		if (v < -32'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction
	function automatic logic signed [18:0] sat19(input logic signed [31:0] v);
		if (v > 32'sd262143) return 19'sh3ffff;
		if (v < -32'sd262144) return 19'sh40000;
		return v[18:0];
	endfunction

	logic signed [31:0] den, tnum, qs;
	assign den  = a_q + cs(cal_q[CAL_MD]);
	assign tnum = cs(cal_q[CAL_MC]) <<< 11;
	assign qs   = neg_q ? -$signed(drsp.quot) : $signed(drsp.quot);

	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = '0;
		if (state_q == S_T2 && den != 0) begin
			dreq.start = 1'b1;
			dreq.num   = tnum[31] ? 32'(-tnum) : tnum;
			dreq.den   = den[31] ? 32'(-den) : den;
		end else if (state_q == S_P8 && b4_q != 0) begin
			dreq.start = 1'b1;
			dreq.num   = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
			dreq.den   = b4_q;
		end
	end

	assign in_ch.ready  = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.result_kind        = kind_q;
	assign out_ch.temperature_tenths = tout_q;
	assign out_ch.pressure_pa        = pout_q;
	assign out_ch.divide_error       = err_q;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready && in_ch.transfer_ok && in_ch.command == CMD_CALIB
			&& in_ch.calib_index < 4'(NUM_CALIB))
			cal_q[in_ch.calib_index] <= in_ch.calib_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			term_q  <= '0;
			oss_q   <= '0;
		end else begin
			if (cfg_ch.valid) oss_q <= cfg_ch.data;
			unique case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.transfer_ok) begin
					raw_q <= in_ch.raw_sample;
					if (in_ch.command == CMD_TEMP) state_q <= S_T1;
					else if (in_ch.command == CMD_PRES) state_q <= S_P1;
				end
				S_T1: begin a_q <= mul_p >>> 15; state_q <= S_T2; end
				S_T2: begin
					kind_q <= 1'b0;
					pout_q <= '0;
					neg_q  <= tnum[31] ^ den[31];
					if (den == 0) begin
						err_q <= 1'b1; tout_q <= '0; state_q <= S_OUT;
					end else state_q <= S_TDIV;
				end
				S_TDIV: if (drsp.done) begin
					term_q <= a_q + qs;
					tout_q <= sat16(((a_q + qs) + 32'sd8) >>> 4);
					err_q  <= 1'b0;
					state_q <= S_OUT;
				end
				S_P1: begin a_q <= mul_p >>> 12; state_q <= S_P2; end
				S_P2: begin b_q <= mul_p >>> 11; state_q <= S_P3; end
				S_P3: begin b_q <= b_q + (mul_p >>> 11); state_q <= S_P4; end
				S_P4: begin b7_q <= mul_p; state_q <= S_P5; end
				S_P5: begin b_q <= mul_p >>> 13; state_q <= S_P6; end
				S_P6: begin d_q <= mul_p >>> 16; state_q <= S_P7; end
				S_P7: begin b4_q <= {15'd0, mul_p[31:15]}; state_q <= S_P8; end
				S_P8: begin
					kind_q <= 1'b1;
					big_q  <= b7_q[31];
					if (b4_q == 0) begin
						err_q <= 1'b1; tout_q <= '0; pout_q <= '0; state_q <= S_OUT;
					end else state_q <= S_PDIV;
				end
				S_PDIV: if (drsp.done) begin
					c_q <= big_q ? $signed({drsp.quot[30:0], 1'b0}) : $signed(drsp.quot);
					state_q <= S_P9;
				end
				S_P9: begin a_q <= mul_p; state_q <= S_P10; end
				S_P10: begin a_q <= mul_p >>> 16; state_q <= S_P11; end
				S_P11: begin b_q <= mul_p >>> 16; state_q <= S_P12; end
				S_P12: begin
					pout_q <= sat19(pnew);
					tout_q <= sat16(t4);
					err_q  <= 1'b0;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: test/bpc_checker.sv
// Result checker for the barometric pressure compensation unit.
// Watches the input, result and configuration channels, predicts results and compares them.
// Depends on bpc_pkg and the three channel interfaces.
module bpc_checker
	import bpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	bpc_in_if    in_mon,
	bpc_out_if   out_mon,
	bpc_cfg_if   cfg_mon,
	output int   errors,
	output int   pending,
	output int   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] temp;
		logic signed [18:0] pres;
		logic               err;
	} reading_t;

	logic [15:0] cal_words [NUM_CALIB];
	int          temp_term;
	logic [1:0]  oss;
	reading_t    reading_q [$];

	initial begin
		for (int i = 0; i < NUM_CALIB; i++) cal_words[i] = '0;
		temp_term = 0;
		oss = '0;
		errors = 0;
		pending = 0;
		checked = 0;
	end

	function automatic int cs(logic [3:0] i);
		return int'(signed'(cal_words[i]));
	endfunction

	function automatic int cu(logic [3:0] i);
		return int'({16'd0, cal_words[i]});
	endfunction

	function automatic logic signed [15:0] temp_tenths();
		int t;
		t = (temp_term + 8) >>> 4;
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return t[15:0];
	endfunction

	// Returns 1 when the transaction yields a reading.
	function automatic bit compensate(logic [1:0] cmd, logic [3:0] idx, logic [15:0] word,
			logic [23:0] raw, logic ok, output reading_t r);
		int ut, x1, x2, x3, den, up, b6, sq, b3, p, sh;
		int unsigned b4, b7, q, t32;
		longint unsigned prod;
		r = '0;
		if (!ok) return 0;
		case (cmd)
			CMD_CALIB: begin
				if (idx < NUM_CALIB) cal_words[idx] = word;
				return 0;
			end
			CMD_TEMP: begin
				ut = int'({16'd0, raw[15:0]});
				x1 = ((ut - cu(CAL_AC6)) * cu(CAL_AC5)) >>> 15;
				den = x1 + cs(CAL_MD);
				if (den == 0) begin
					r.err = 1'b1;
					return 1;
				end
				x2 = int'(longint'(cs(CAL_MC) << 11) / longint'(den));
				temp_term = x1 + x2;
				r.temp = temp_tenths();
				return 1;
			end
			CMD_PRES: begin
				r.kind = 1'b1;
				sh = 8 - int'(oss);
				up = int'({8'd0, raw} >> sh);
				b6 = temp_term - 4000;
				sq = (b6 * b6) >>> 12;
				x1 = (cs(CAL_B2) * sq) >>> 11;
				x2 = (cs(CAL_AC2) * b6) >>> 11;
				x3 = x1 + x2;
				b3 = (((cs(CAL_AC1) * 4 + x3) << oss) + 2) >>> 2;
				x1 = (cs(CAL_AC3) * b6) >>> 13;
				x2 = (cs(CAL_B1) * sq) >>> 16;
				x3 = (x1 + x2 + 2) >>> 2;
				t32 = x3 + 32768;
				prod = longint'(cu(CAL_AC4)) * longint'({32'd0, t32});
				b4 = prod[31:0] >> 15;
				t32 = up - b3;
				prod = {32'd0, t32} * longint'(50000 >> oss);
				b7 = prod[31:0];
				if (b4 == 0) begin
					r.err = 1'b1;
					return 1;
				end
				if (b7 < 32'h8000_0000) q = (b7 << 1) / b4;
				else q = (b7 / b4) << 1;
				p = int'(q);
				x1 = (p >>> 8) * (p >>> 8);
				x1 = (x1 * 3038) >>> 16;
				x2 = (-7357 * p) >>> 16;
				p = p + ((x1 + x2 + 3791) >>> 4);
				if (p > 262143) p = 262143;
				if (p < -262144) p = -262144;
				r.temp = temp_tenths();
				r.pres = p[18:0];
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	always @(posedge clk) begin
		reading_t r, got;
		if (arst_n) begin
			if (cfg_mon.valid && cfg_mon.ready) oss <= cfg_mon.data;
			if (in_mon.valid && in_mon.ready) begin
				if (compensate(in_mon.command, in_mon.calib_index, in_mon.calib_word,
						in_mon.raw_sample, in_mon.transfer_ok, r))
					reading_q.push_back(r);
			end
			if (out_mon.valid && out_mon.ready) begin
				got = {out_mon.result_kind, out_mon.temperature_tenths, out_mon.pressure_pa,
					out_mon.divide_error};
				if (reading_q.size() == 0) begin
					$display("%0t: result with none expected: kind %0d temp %0d pres %0d err %0d",
						$realtime, got.kind, got.temp, got.pres, got.err);
					errors++;
				end else begin
					r = reading_q.pop_front();
					checked++;
					if (got !== r) begin
						$display("%0t: mismatch expected kind %0d temp %0d pres %0d err %0d, actual kind %0d temp %0d pres %0d err %0d",
							$realtime, r.kind, r.temp, r.pres, r.err,
							got.kind, got.temp, got.pres, got.err);
						errors++;
					end
				end
			end
			pending <= reading_q.size();
		end
	end
endmodule

FILE: test/tb.sv
// Top of the compensation unit testbench: clock, reset, stimulus and verdict.
// Depends on bpc_pkg, the channel interfaces, bpc_checker and the unit itself.
module tb;
	import bpc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 120;

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   errors, pending, checked;
	int   stall_cycles;
	int   sent;

	bpc_in_if  in_ch();
	bpc_out_if out_ch();
	bpc_cfg_if cfg_ch();

	barometric_pressure_compensation_unit DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch));

	bpc_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
		.errors(errors), .pending(pending), .checked(checked));

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.command = CMD_CALIB;
		in_ch.calib_index = '0;
		in_ch.calib_word = '0;
		in_ch.raw_sample = '0;
		in_ch.transfer_ok = 0;
		out_ch.ready = 0;
		cfg_ch.valid = 0;
		cfg_ch.data = '0;
	end

	always @(posedge clk)
		out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 33);

	// Any accepted transaction counts as progress.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired with %0d results pending", $realtime, pending);
			$display("FAIL barometric_pressure_compensation_unit");
			$finish;
		end
	end

	task automatic send(logic [1:0] cmd, logic [3:0] idx, logic [15:0] word,
			logic [23:0] raw, logic ok);
		while (!no_idle && $urandom_range(0, 99) < 33) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.command <= cmd;
		in_ch.calib_index <= idx;
		in_ch.calib_word <= word;
		in_ch.raw_sample <= raw;
		in_ch.transfer_ok <= ok;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (ok && (cmd == CMD_TEMP || cmd == CMD_PRES)) sent++;
	endtask

	task automatic load_cal(logic [3:0] idx, logic [15:0] word);
		send(CMD_CALIB, idx, word, 24'($urandom), 1'b1);
	endtask

	task automatic load_typical();
		load_cal(CAL_AC1, 16'(408));
		load_cal(CAL_AC2, 16'(-72));
		load_cal(CAL_AC3, 16'(-14383));
		load_cal(CAL_AC4, 16'(32741));
		load_cal(CAL_AC5, 16'(32757));
		load_cal(CAL_AC6, 16'(23153));
		load_cal(CAL_B1, 16'(6190));
		load_cal(CAL_B2, 16'(4));
		load_cal(CAL_MB, 16'(-32768));
		load_cal(CAL_MC, 16'(-8711));
		load_cal(CAL_MD, 16'(2868));
	endtask

	// Drain results, let any last calibration load settle, then write oversampling.
	task automatic set_oversampling(logic [1:0] value);
		in_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 0;
	endtask

	task automatic random_item();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			send(CMD_TEMP, 4'($urandom), 16'($urandom),
				($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(20000, 40000)),
				1'b1);
		else if (roll < 80)
			send(CMD_PRES, 4'($urandom), 16'($urandom), 24'($urandom), 1'b1);
		else if (roll < 85)
			load_cal(4'($urandom_range(0, NUM_CALIB - 1)), 16'($urandom));
		else if (roll < 90)
			send(CMD_CALIB, 4'($urandom_range(NUM_CALIB, 15)), 16'($urandom), 24'($urandom), 1'b1);
		else if (roll < 95)
			send(CMD_NONE, 4'($urandom), 16'($urandom), 24'($urandom), 1'b1);
		else
			send(2'($urandom), 4'($urandom), 16'($urandom), 24'($urandom), 1'b0);
	endtask

	initial begin
		no_idle = 0;
		sent = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		set_oversampling(2'd0);
		load_typical();
		send(CMD_CALIB, CAL_AC1, 16'hFFFF, 24'h0, 1'b0);
		send(CMD_CALIB, 4'd11, 16'hAAAA, 24'h0, 1'b1);
		send(CMD_CALIB, 4'd15, 16'h5555, 24'h0, 1'b1);
		send(CMD_NONE, 4'd0, 16'h0, 24'hFFFFFF, 1'b1);
		send(CMD_TEMP, 4'd0, 16'h0, 24'd27898, 1'b1);
		send(CMD_PRES, 4'd0, 16'h0, 24'd23843 << 8, 1'b1);
		send(CMD_TEMP, 4'd0, 16'h0, 24'd0, 1'b1);
		send(CMD_TEMP, 4'd0, 16'h0, 24'hFFFFFF, 1'b1);
		send(CMD_PRES, 4'd0, 16'h0, 24'd0, 1'b1);
		send(CMD_PRES, 4'd0, 16'h0, 24'hFFFFFF, 1'b1);
		send(CMD_TEMP, 4'd0, 16'h0, 24'd27898, 1'b0);
		// zero temperature divisor, then a saturating temperature term
		load_cal(CAL_AC5, 16'd0);
		load_cal(CAL_MD, 16'd0);
		send(CMD_TEMP, 4'd0, 16'h0, 24'd27898, 1'b1);
		load_cal(CAL_MD, 16'd1);
		send(CMD_TEMP, 4'd0, 16'h0, 24'd27898, 1'b1);
		send(CMD_PRES, 4'd0, 16'h0, 24'hFFFFFF, 1'b1);
		// zero pressure divisor
		load_cal(CAL_AC4, 16'd0);
		send(CMD_PRES, 4'd0, 16'h0, 24'h123456, 1'b1);

		for (int phase = 0; phase < 8; phase++) begin
			logic [1:0] oss_value;
			int target;
			case (phase)
				0: oss_value = 2'd3;
				1: oss_value = 2'd1;
				2: oss_value = 2'd2;
				3: oss_value = 2'd0;
				default: oss_value = 2'($urandom);
			endcase
			set_oversampling(oss_value);
			no_idle = (phase == 3);
			if (phase % 2 == 0)
				load_typical();
			else
				for (int i = 0; i < NUM_CALIB; i++) load_cal(4'(i), 16'($urandom));
			send(CMD_TEMP, 4'd0, 16'h0, 24'($urandom_range(20000, 40000)), 1'b1);
			target = sent + 70;
			while (sent < target) random_item();
		end
		no_idle = 0;
		in_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d temperature and pressure samples, checked %0d results,", sent, checked);
		$display("over all four oversampling settings with typical and random calibration.");
		if (errors == 0 && pending == 0)
			$display("PASS barometric_pressure_compensation_unit");
		else
			$display("FAIL barometric_pressure_compensation_unit");
		$finish;
	end
endmodule

FILE: barometric_pressure_compensation_unit.f
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_in_if.sv
hw/rtl/bpc_out_if.sv
hw/rtl/bpc_cfg_if.sv
hw/rtl/bpc_div.sv
hw/rtl/barometric_pressure_compensation_unit.sv
test/bpc_checker.sv
test/tb.sv
